// ===== hw/rtl/pas_pkg.sv =====
package pas_pkg;

  // Function codes of a request beat
  localparam logic [1:0] FN_ALLOC_MODEL = 2'd0;
  localparam logic [1:0] FN_ALLOC_PLAIN = 2'd1;
  localparam logic [1:0] FN_ALLOC_HIGH  = 2'd2;
  localparam logic [1:0] FN_RELEASE     = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOMODEL   = 3'd2;
  localparam logic [2:0] ST_NOVICTIM  = 3'd3;
  localparam logic [2:0] ST_NOTACTIVE = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic       model_present;
    logic [8:0] release_index;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] entry_index;
    logic       reclaimed;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_TAKE,
    S_STEAL_CHK,
    S_STEAL_EVAL,
    S_REL_CHK,
    S_REL_NEXT,
    S_REL_UNLINK,
    S_REL_FREE,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/pas_store.sv =====
module pas_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  // Link and priority word per pool entry: {is_high, link_next}
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pas_seq.sv =====
module pas_seq import pas_pkg::*; #(
  parameter int POOL_SIZE = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  req_t                             req,
  output logic                             res_valid,
  input  logic                             res_ready,
  output rsp_t                             res,
  output logic                             mem_we,
  output logic [$clog2(POOL_SIZE)-1:0]     mem_waddr,
  output logic [$clog2(POOL_SIZE+1):0]     mem_wdata,
  output logic [$clog2(POOL_SIZE)-1:0]     mem_raddr,
  input  logic [$clog2(POOL_SIZE+1):0]     mem_rdata
);

  localparam int IW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int CW = (LW > 9) ? LW : 9;
  localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

  state_t        state, state_next;
  logic [LW-1:0] free_head, free_head_next;
  logic [LW-1:0] active_head, active_head_next;
  logic [LW-1:0] cur, cur_next;
  logic [LW-1:0] prev, prev_next;
  logic          prev_hi, prev_hi_next;
  logic [LW-1:0] cnt, cnt_next;
  logic          high, high_next;
  logic [8:0]    idx, idx_next;
  rsp_t          res_next;

  logic          rd_hi;
  logic [LW-1:0] rd_link;
  logic          free_null;
  logic          cur_stop;
  logic          cur_match;

  assign rd_hi     = mem_rdata[LW];
  assign rd_link   = mem_rdata[LW-1:0];
  assign free_null = (free_head >= NIL);
  // walk ends at a null link or after a full pool of steps
  assign cur_stop  = (cur >= NIL) || (cnt == NIL);
  // compare of the walked entry against the release target
  assign cur_match = (CW'(cur) == CW'(idx));

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      free_head   <= '0;
      active_head <= NIL;
      cnt         <= '0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      active_head <= active_head_next;
      cnt         <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    prev    <= prev_next;
    prev_hi <= prev_hi_next;
    high    <= high_next;
    idx     <= idx_next;
    res     <= res_next;
  end

  // Sequencer: next state, memory port and result
  always_comb begin
    state_next       = state;
    free_head_next   = free_head;
    active_head_next = active_head;
    cur_next         = cur;
    prev_next        = prev;
    prev_hi_next     = prev_hi;
    cnt_next         = cnt;
    high_next        = high;
    idx_next         = idx;
    res_next         = res;
    mem_we           = 1'b0;
    mem_waddr        = free_head[IW-1:0];
    mem_wdata        = '0;
    mem_raddr        = free_head[IW-1:0];
    req_ready        = 1'b0;
    res_valid        = 1'b0;

    case (state)
      // clearing pass: entry i links i+1, low priority
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[IW-1:0];
        mem_wdata = {1'b0, cnt + LW'(1)};
        cnt_next  = cnt + LW'(1);
        if (cnt == NIL - LW'(1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end

      // link of the free head is read here, used if the beat takes a free entry
      S_IDLE: begin
        req_ready = 1'b1;
        res_next  = '{status: ST_OK, entry_index: 9'd0, reclaimed: 1'b0};
        cnt_next  = '0;
        cur_next  = active_head;
        prev_next = NIL;
        idx_next  = req.release_index;
        if (req_valid) begin
          case (req.func)
            FN_ALLOC_MODEL, FN_ALLOC_PLAIN: begin
              high_next = 1'b0;
              if (free_null) begin
                res_next.status = ST_EMPTY;
                state_next      = S_DONE;
              end else if (req.func == FN_ALLOC_MODEL && !req.model_present) begin
                res_next.status = ST_NOMODEL;
                state_next      = S_DONE;
              end else begin
                state_next = S_TAKE;
              end
            end
            FN_ALLOC_HIGH: begin
              high_next = 1'b1;
              if (!req.model_present) begin
                res_next.status = ST_NOMODEL;
                state_next      = S_DONE;
              end else if (!free_null) begin
                state_next = S_TAKE;
              end else begin
                state_next = S_STEAL_CHK;
              end
            end
            FN_RELEASE: begin
              state_next = S_REL_CHK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // pop free head, push onto active head
      S_TAKE: begin
        mem_we               = 1'b1;
        mem_waddr            = free_head[IW-1:0];
        mem_wdata            = {high, active_head};
        free_head_next       = rd_link;
        active_head_next     = free_head;
        res_next.entry_index = 9'(free_head);
        state_next           = S_DONE;
      end

      S_STEAL_CHK: begin
        mem_raddr = cur[IW-1:0];
        if (cur_stop) begin
          res_next.status = ST_NOVICTIM;
          state_next      = S_DONE;
        end else begin
          state_next = S_STEAL_EVAL;
        end
      end

      // low-priority entry found: mark it high in place; else follow its link
      S_STEAL_EVAL: begin
        if (!rd_hi) begin
          mem_we               = 1'b1;
          mem_waddr            = cur[IW-1:0];
          mem_wdata            = {1'b1, rd_link};
          res_next.entry_index = 9'(cur);
          res_next.reclaimed   = 1'b1;
          state_next           = S_DONE;
        end else begin
          cur_next   = rd_link;
          cnt_next   = cnt + LW'(1);
          state_next = S_STEAL_CHK;
        end
      end

      S_REL_CHK: begin
        mem_raddr = cur[IW-1:0];
        if (cur_stop) begin
          res_next.status = ST_NOTACTIVE;
          state_next      = S_DONE;
        end else if (cur_match) begin
          state_next = S_REL_UNLINK;
        end else begin
          state_next = S_REL_NEXT;
        end
      end

      S_REL_NEXT: begin
        prev_next    = cur;
        prev_hi_next = rd_hi;
        cur_next     = rd_link;
        cnt_next     = cnt + LW'(1);
        state_next   = S_REL_CHK;
      end

      // bypass the target: predecessor (or active head) takes its link
      S_REL_UNLINK: begin
        if (prev < NIL) begin
          mem_we    = 1'b1;
          mem_waddr = prev[IW-1:0];
          mem_wdata = {prev_hi, rd_link};
        end else begin
          active_head_next = rd_link;
        end
        state_next = S_REL_FREE;
      end

      // push target onto free list, priority mark cleared
      S_REL_FREE: begin
        mem_we               = 1'b1;
        mem_waddr            = cur[IW-1:0];
        mem_wdata            = {1'b0, free_head};
        free_head_next       = cur;
        res_next.entry_index = 9'(cur);
        state_next           = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pool_allocator_priority_steal.sv =====
// Channel | Signals                      | Beat
// req     | req_valid, req_ready, req    | func, model_present, release_index
// rsp     | rsp_valid, rsp_ready, rsp    | status, entry_index, reclaimed
//
// After reset a clearing pass over all POOL_SIZE entries builds the free list, req_ready low.
// Alloc from the free list passes S_TAKE; early errors go straight to S_DONE.
// Steal walks high entries ahead of the victim, or every active entry if none is low.
// Release walks the entries ahead of the target, then unlinks and frees it, or walks
// every active entry on a miss; each walk step costs one registered link read.
// A stalled rsp blocks the sequencer only when a new result meets a full rsp register.
module pool_allocator_priority_steal import pas_pkg::*; #(
  parameter int POOL_SIZE = 512
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);

  logic          res_valid;
  logic          res_ready;
  rsp_t          res;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [LW:0]   mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [LW:0]   mem_rdata;

  pas_seq #(
    .POOL_SIZE(POOL_SIZE)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pas_store #(
    .DEPTH(POOL_SIZE),
    .AW   (IW),
    .DW   (LW + 1)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("sequencer ready right after taking a beat");

  a_reclaim_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reclaimed |-> rsp.status == ST_OK)
    else $error("reclaim flagged on a failed request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_NOTACTIVE)
    else $error("status code out of range");

  a_reset_init: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("reset did not start the clearing pass");

endmodule
